/* hdl/clnbc_pkg.sv */
// Shared types and constants for the character LCD nibble bus controller.
package clnbc_pkg;

	localparam logic [2:0] OP_CMD    = 3'd0;
	localparam logic [2:0] OP_DATA   = 3'd1;
	localparam logic [2:0] OP_CURSOR = 3'd2;
	localparam logic [2:0] OP_CLEAR  = 3'd3;
	localparam logic [2:0] OP_INIT   = 3'd4;
	localparam logic [2:0] OP_STATUS = 3'd5;

	localparam logic [1:0] REG_BUSY_MASK    = 2'd0;
	localparam logic [1:0] REG_FUNCTION_SET = 2'd1;
	localparam logic [1:0] REG_DISPLAY_CTRL = 2'd2;
	localparam logic [1:0] REG_ENTRY_MODE   = 2'd3;

	localparam logic [7:0] BUSY_MASK_RST    = 8'h80;
	localparam logic [7:0] FUNCTION_SET_RST = 8'h28;
	localparam logic [7:0] DISPLAY_CTRL_RST = 8'h0C;
	localparam logic [7:0] ENTRY_MODE_RST   = 8'h06;

	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_DDRAM_ADDR = 8'h80;
	localparam logic [3:0] INIT_NIBBLE    = 4'h2;

	// row address offset for the second display line
	localparam logic [7:0] ROW_STRIDE = 8'd64;

	// words queued behind the one in flight
	localparam int PEND_DEPTH = 4;
	// results held for the output side
	localparam int RES_DEPTH  = 4;
	// most results one input word can cause
	localparam int MAX_RES    = 3;

	typedef logic [8:0] lcd_word_t;

	typedef struct packed {
		logic       reg_select;
		logic       read_cycle;
		logic [3:0] nibble_out;
		logic       rejected;
		logic       last;
	} bus_res_t;

endpackage

/* hdl/char_lcd_nibble_bus_controller_unit.sv */
// Character LCD 4-bit bus controller: request sequencer, busy poll and result queue.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid / in_ready | op, byte_value, column, row, status_nibble
//  out     | out_valid/out_ready | reg_select, read_cycle, nibble_out, rejected, last
//  cfg     | cfg_we              | cfg_index, cfg_data
//
//  An accepted word is decoded and its zero to three bus cycles are
//  pushed into a four-entry result queue; one bus cycle leaves per out handshake.
//  in_ready is high while the queue, after this cycle's pop, holds at most one entry,
//  so a word that gives one bus cycle can be taken every cycle while the out side keeps up.
//  arst_n clears the sequencer and the queue and loads the configuration registers with their reset values at once.
//  A stalled out side leaves entries in the queue, and once it holds two or more in_ready stays low.
module char_lcd_nibble_bus_controller_unit (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] op,
	input  logic [7:0] byte_value,
	input  logic [5:0] column,
	input  logic       row,
	input  logic [3:0] status_nibble,

	output logic       out_valid,
	input  logic       out_ready,
	output logic       reg_select,
	output logic       read_cycle,
	output logic [3:0] nibble_out,
	output logic       rejected,
	output logic       last,

	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import clnbc_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HIGH,
		PH_LOW
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [3:0] status_high_q, status_high_d;
	lcd_word_t  cur_word_q, cur_word_d;
	lcd_word_t  pend_q [PEND_DEPTH];
	lcd_word_t  pend_d [PEND_DEPTH];
	logic [2:0] pend_cnt_q, pend_cnt_d;

	logic [7:0] busy_mask_q, function_set_q, display_ctrl_q, entry_mode_q;

	bus_res_t   res_q [RES_DEPTH];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;

	bus_res_t   batch [MAX_RES];
	logic [1:0] push_n;
	logic       in_acc, pop;
	logic [2:0] occ_after_pop;
	logic [7:0] cursor_addr;
	logic [7:0] status_full;
	logic       word_rs;

	localparam bus_res_t RES_READ = '{reg_select: 1'b0, read_cycle: 1'b1,
		nibble_out: 4'h0, rejected: 1'b0, last: 1'b0};
	localparam bus_res_t RES_REJECT = '{reg_select: 1'b0, read_cycle: 1'b0,
		nibble_out: 4'h0, rejected: 1'b1, last: 1'b0};
	localparam bus_res_t RES_INIT = '{reg_select: 1'b0, read_cycle: 1'b0,
		nibble_out: INIT_NIBBLE, rejected: 1'b0, last: 1'b0};

	assign pop           = out_valid & out_ready;
	assign occ_after_pop = count_q - {2'b00, pop};
	assign in_ready      = (occ_after_pop <= 3'd1);
	assign in_acc        = in_valid & in_ready;

	assign out_valid  = (count_q != 3'd0);
	assign reg_select = res_q[rd_ptr_q].reg_select;
	assign read_cycle = res_q[rd_ptr_q].read_cycle;
	assign nibble_out = res_q[rd_ptr_q].nibble_out;
	assign rejected   = res_q[rd_ptr_q].rejected;
	assign last       = res_q[rd_ptr_q].last;

	assign cursor_addr = CMD_DDRAM_ADDR | ({2'b00, column} + (row ? ROW_STRIDE : 8'd0));
	assign status_full = {status_high_q, status_nibble};
	assign word_rs     = cur_word_q[8];

	always_comb begin
		phase_d       = phase_q;
		status_high_d = status_high_q;
		cur_word_d    = cur_word_q;
		pend_cnt_d    = pend_cnt_q;
		for (int i = 0; i < PEND_DEPTH; i++) begin
			pend_d[i] = pend_q[i];
		end
		for (int i = 0; i < MAX_RES; i++) begin
			batch[i] = RES_READ;
		end
		push_n = 2'd0;

		if (op <= OP_INIT) begin
			if (phase_q != PH_IDLE) begin
				batch[0] = RES_REJECT;
				push_n   = 2'd1;
			end else begin
				phase_d    = PH_HIGH;
				pend_cnt_d = 3'd0;
				push_n     = 2'd1;
				case (op)
					OP_CMD: begin
						cur_word_d = {1'b0, byte_value};
					end
					OP_DATA: begin
						cur_word_d = {1'b1, byte_value};
					end
					OP_CURSOR: begin
						cur_word_d = {1'b0, cursor_addr};
					end
					OP_CLEAR: begin
						cur_word_d = {1'b0, CMD_CLEAR};
						pend_d[0]  = {1'b0, CMD_DDRAM_ADDR};
						pend_cnt_d = 3'd1;
					end
					default: begin
						cur_word_d = {1'b0, function_set_q};
						pend_d[0]  = {1'b0, display_ctrl_q};
						pend_d[1]  = {1'b0, entry_mode_q};
						pend_d[2]  = {1'b0, CMD_DDRAM_ADDR};
						pend_cnt_d = 3'd3;
						batch[0]   = RES_INIT;
						push_n     = 2'd2;
					end
				endcase
			end
		end else if (op == OP_STATUS) begin
			case (phase_q)
				PH_HIGH: begin
					status_high_d = status_nibble;
					phase_d       = PH_LOW;
					push_n        = 2'd1;
				end
				PH_LOW: begin
					if ((status_full & busy_mask_q) != 8'd0) begin
						phase_d = PH_HIGH;
						push_n  = 2'd1;
					end else begin
						batch[0] = '{reg_select: word_rs, read_cycle: 1'b0,
							nibble_out: cur_word_q[7:4], rejected: 1'b0, last: 1'b0};
						batch[1] = '{reg_select: word_rs, read_cycle: 1'b0,
							nibble_out: cur_word_q[3:0], rejected: 1'b0, last: 1'b0};
						if (pend_cnt_q != 3'd0) begin
							cur_word_d = pend_q[0];
							for (int i = 0; i < PEND_DEPTH - 1; i++) begin
								pend_d[i] = pend_q[i + 1];
							end
							pend_cnt_d = pend_cnt_q - 3'd1;
							phase_d    = PH_HIGH;
							push_n     = 2'd3;
						end else begin
							phase_d = PH_IDLE;
							push_n  = 2'd2;
						end
					end
				end
				default: begin
					push_n = 2'd0;
				end
			endcase
		end

		for (int i = 0; i < MAX_RES; i++) begin
			batch[i].last = (push_n != 2'd0) && (2'(i) == push_n - 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			status_high_q  <= 4'h0;
			cur_word_q     <= '0;
			pend_cnt_q     <= 3'd0;
			for (int i = 0; i < PEND_DEPTH; i++) begin
				pend_q[i] <= '0;
			end
			for (int i = 0; i < RES_DEPTH; i++) begin
				res_q[i] <= '0;
			end
			wr_ptr_q       <= 2'd0;
			rd_ptr_q       <= 2'd0;
			count_q        <= 3'd0;
			busy_mask_q    <= BUSY_MASK_RST;
			function_set_q <= FUNCTION_SET_RST;
			display_ctrl_q <= DISPLAY_CTRL_RST;
			entry_mode_q   <= ENTRY_MODE_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BUSY_MASK:    busy_mask_q    <= cfg_data;
					REG_FUNCTION_SET: function_set_q <= cfg_data;
					REG_DISPLAY_CTRL: display_ctrl_q <= cfg_data;
					REG_ENTRY_MODE:   entry_mode_q   <= cfg_data;
					default:          busy_mask_q    <= busy_mask_q;
				endcase
			end
			if (in_acc) begin
				phase_q       <= phase_d;
				status_high_q <= status_high_d;
				cur_word_q    <= cur_word_d;
				pend_cnt_q    <= pend_cnt_d;
				for (int i = 0; i < PEND_DEPTH; i++) begin
					pend_q[i] <= pend_d[i];
				end
				for (int j = 0; j < RES_DEPTH; j++) begin
					if ((2'(j) - wr_ptr_q) < push_n) begin
						res_q[j] <= batch[2'(j) - wr_ptr_q];
					end
				end
				wr_ptr_q <= wr_ptr_q + push_n;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= occ_after_pop + (in_acc ? {1'b0, push_n} : 3'd0);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(RES_DEPTH))
		else $error("result queue overfilled");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q <= 3'(MAX_RES))
		else $error("pending word count out of range");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> pend_cnt_q == 3'd0)
		else $error("words pending while idle");

	a_start_polls: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && phase_q == PH_IDLE && op <= OP_INIT |=> phase_q == PH_HIGH)
		else $error("accepted request did not start a busy poll");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && phase_q != PH_IDLE && op <= OP_INIT
		|=> $stable(cur_word_q) && $stable(pend_cnt_q))
		else $error("rejected request disturbed the running sequence");

endmodule
